/* src/cprq_pkg.sv */
// cprq_pkg: shared types, codes and helpers of the class priority request queue
// used by cprq_cell and class_priority_request_queue; no dependencies
`timescale 1ns / 1ps

package cprq_pkg;

  localparam int DEFAULT_DEPTH = 16;
  localparam int LEVEL_COUNT   = 6;

  // command modes
  localparam logic [1:0] MODE_PUT   = 2'd0;
  localparam logic [1:0] MODE_GET   = 2'd1;
  localparam logic [1:0] MODE_TERM  = 2'd2;
  localparam logic [1:0] MODE_SPARE = 2'd3;

  // event classes
  localparam logic [2:0] CLASS_ADMIN      = 3'd0;
  localparam logic [2:0] CLASS_SHUTDOWN   = 3'd1;
  localparam logic [2:0] CLASS_DISCONNECT = 3'd2;
  localparam logic [2:0] CLASS_NETWORK    = 3'd3;
  localparam logic [2:0] CLASS_TIMER      = 3'd4;
  localparam logic [2:0] CLASS_WINDOW     = 3'd5;
  localparam logic [2:0] CLASS_IDLE       = 3'd6;
  localparam logic [2:0] CLASS_SYNC       = 3'd7;

  // result status codes
  localparam logic [2:0] ST_QUEUED    = 3'd0;
  localparam logic [2:0] ST_DUP       = 3'd1;
  localparam logic [2:0] ST_TERM_DROP = 3'd2;
  localparam logic [2:0] ST_FULL      = 3'd3;
  localparam logic [2:0] ST_GIVEN     = 3'd4;
  localparam logic [2:0] ST_EMPTY     = 3'd5;
  localparam logic [2:0] ST_CLEARED   = 3'd6;

  // level register indexes
  localparam logic [2:0] REG_SHUTDOWN = 3'd0;
  localparam logic [2:0] REG_NETWORK  = 3'd1;
  localparam logic [2:0] REG_TIMER    = 3'd2;
  localparam logic [2:0] REG_WINDOW   = 3'd3;
  localparam logic [2:0] REG_IDLE     = 3'd4;
  localparam logic [2:0] REG_DEFAULT  = 3'd5;

  typedef logic [LEVEL_COUNT-1:0][7:0] levels_t;

  localparam levels_t LEVELS_RESET = {8'd50, 8'd100, 8'd75, 8'd70, 8'd50, 8'd0};

  // request fields the cells compare against
  typedef struct packed {
    logic [31:0] win;
    logic [31:0] wrd;
    logic [31:0] lng;
  } cmd_t;

  // running result handed from cell to cell
  typedef struct packed {
    logic        found;
    logic [7:0]  lev;
    logic [31:0] seq;
    logic [2:0]  cls;
    logic        tmr;
    logic [31:0] win;
    logic [31:0] wrd;
    logic [31:0] lng;
    logic        dup;
    logic        free;
  } carry_t;

  // entry write broadcast
  typedef struct packed {
    logic        en;
    logic [2:0]  cls;
    logic [31:0] seq;
    logic        tmr;
    logic [31:0] win;
    logic [31:0] wrd;
    logic [31:0] lng;
  } wr_t;

  function automatic logic [7:0] level_of(input logic [2:0] cls, input levels_t lv);
    logic [7:0] r;
    case (cls)
      CLASS_SHUTDOWN:                r = lv[REG_SHUTDOWN];
      CLASS_DISCONNECT, CLASS_NETWORK: r = lv[REG_NETWORK];
      CLASS_TIMER:                   r = lv[REG_TIMER];
      CLASS_WINDOW:                  r = lv[REG_WINDOW];
      CLASS_IDLE:                    r = lv[REG_IDLE];
      default:                       r = lv[REG_DEFAULT];
    endcase
    return r;
  endfunction

endpackage

/* src/cprq_cell.sv */
// cprq_cell: one queue slot plus its stage of the selection chain
// depends on cprq_pkg
`timescale 1ns / 1ps

module cprq_cell #(
  parameter int IDX_W   = 4,
  parameter int CELL_ID = 0
) (
  input  logic              clk,
  input  logic              rst_n,
  input  cprq_pkg::levels_t levels,
  input  cprq_pkg::cmd_t    cmd,
  input  cprq_pkg::carry_t  carry_i,
  input  logic [IDX_W-1:0]  bidx_i,
  input  logic [IDX_W-1:0]  fidx_i,
  output cprq_pkg::carry_t  carry_o,
  output logic [IDX_W-1:0]  bidx_o,
  output logic [IDX_W-1:0]  fidx_o,
  input  cprq_pkg::wr_t     wr,
  input  logic [IDX_W-1:0]  wr_idx,
  input  logic              kill_en,
  input  logic [IDX_W-1:0]  kill_idx,
  input  logic              clear
);

  localparam logic [IDX_W-1:0] ID = IDX_W'(CELL_ID);

  logic             valid_r, valid_nxt;
  logic [2:0]       cls_r;
  logic [31:0]      seq_r;
  logic             tmr_r;
  logic [31:0]      win_r, wrd_r, lng_r;
  cprq_pkg::carry_t carry_r, carry_nxt;
  logic [IDX_W-1:0] bidx_r, bidx_nxt, fidx_r, fidx_nxt;
  logic [7:0]       lev;
  logic             better, match;

  always_comb begin
    lev    = cprq_pkg::level_of(cls_r, levels);
    // strictly better only, so an exact tie keeps the lower slot
    better = valid_r && (!carry_i.found || lev < carry_i.lev ||
             (lev == carry_i.lev && seq_r < carry_i.seq));
    match  = valid_r && cls_r == cprq_pkg::CLASS_WINDOW && tmr_r &&
             win_r == cmd.win && wrd_r == cmd.wrd && lng_r == cmd.lng;
    carry_nxt = carry_i;
    bidx_nxt  = bidx_i;
    fidx_nxt  = fidx_i;
    if (better) begin
      carry_nxt.found = 1'b1;
      carry_nxt.lev   = lev;
      carry_nxt.seq   = seq_r;
      carry_nxt.cls   = cls_r;
      carry_nxt.tmr   = tmr_r;
      carry_nxt.win   = win_r;
      carry_nxt.wrd   = wrd_r;
      carry_nxt.lng   = lng_r;
      bidx_nxt        = ID;
    end
    if (match) carry_nxt.dup = 1'b1;
    if (!carry_i.free && !valid_r) begin
      carry_nxt.free = 1'b1;
      fidx_nxt       = ID;
    end
    valid_nxt = valid_r;
    if (wr.en && wr_idx == ID) valid_nxt = 1'b1;
    if (kill_en && kill_idx == ID) valid_nxt = 1'b0;
    if (clear) valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      carry_r <= '0;
      bidx_r  <= '0;
      fidx_r  <= '0;
    end else begin
      valid_r <= valid_nxt;
      carry_r <= carry_nxt;
      bidx_r  <= bidx_nxt;
      fidx_r  <= fidx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr.en && wr_idx == ID) begin
      cls_r <= wr.cls;
      seq_r <= wr.seq;
      tmr_r <= wr.tmr;
      win_r <= wr.win;
      wrd_r <= wr.wrd;
      lng_r <= wr.lng;
    end
  end

  assign carry_o = carry_r;
  assign bidx_o  = bidx_r;
  assign fidx_o  = fidx_r;

endmodule

/* src/class_priority_request_queue.sv */
// class_priority_request_queue: top level, command sequencer over a chain of slot cells
// depends on cprq_pkg and cprq_cell
`timescale 1ns / 1ps

// Usage
//  - command channel: a transfer happens when start is high and busy is low;
//    in_mode selects put, get most urgent or terminate
//  - each command gives one result, shown for one cycle with out_valid high;
//    the receiver cannot hold it off
//  - every command runs a pass along the chain of QUEUE_DEPTH cells, one cell
//    per cycle, then the execute state; the result appears the cycle after
//  - a shutdown put makes two passes; a new command is taken in the cycle the result
//    is shown, not before, as busy stays high until then
//  - cfg channel: level registers 0..5, always ready, written while idle: a rule
//    for the user, which the block itself does not enforce
//  - reset empties the queue, zeroes counts and the arrival counter, clears
//    the terminating flag and loads the default levels

module class_priority_request_queue #(
  parameter int QUEUE_DEPTH = cprq_pkg::DEFAULT_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_mode,
  input  logic [2:0]  in_event_class,
  input  logic        in_timer_flag,
  input  logic [31:0] in_window_handle,
  input  logic [31:0] in_word_param,
  input  logic [31:0] in_long_param,
  output logic        out_valid,
  output logic [2:0]  out_status,
  output logic [2:0]  out_class,
  output logic [31:0] out_sequence,
  output logic        out_timer_flag,
  output logic [31:0] out_window,
  output logic [31:0] out_word,
  output logic [31:0] out_long,
  output logic [4:0]  out_occupancy,
  output logic [4:0]  out_network_count,
  output logic [4:0]  out_window_count,
  output logic [4:0]  out_admin_count,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [7:0]  cfg_data
);

  localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [IDX_W-1:0] LAST = IDX_W'(QUEUE_DEPTH - 1);

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_EXEC} state_t;

  state_t            state_r, state_nxt;
  logic [IDX_W-1:0]  cnt_r, cnt_nxt;
  logic              pass2_r, pass2_nxt;
  logic              term_r, term_nxt;
  logic [31:0]       arr_r, arr_nxt;
  logic [CNT_W-1:0]  total_r, total_nxt, net_r, net_nxt, win_r, win_nxt, adm_r, adm_nxt;
  cprq_pkg::levels_t levels_r, levels_nxt;
  logic [1:0]        mode_r, mode_nxt;
  logic [2:0]        cls_r, cls_nxt;
  logic              tmr_r, tmr_nxt;
  cprq_pkg::cmd_t    cmd_r, cmd_nxt;

  logic              ov_r, ov_nxt;
  logic [2:0]        ost_r, ost_nxt, ocls_r, ocls_nxt;
  logic [31:0]       oseq_r, oseq_nxt, owin_r, owin_nxt, owrd_r, owrd_nxt, olng_r, olng_nxt;
  logic              otmr_r, otmr_nxt;
  logic [4:0]        oocc_r, oocc_nxt, onet_r, onet_nxt, owc_r, owc_nxt, oadm_r, oadm_nxt;

  cprq_pkg::carry_t  chain [QUEUE_DEPTH+1];
  logic [IDX_W-1:0]  bidx [QUEUE_DEPTH+1];
  logic [IDX_W-1:0]  fidx [QUEUE_DEPTH+1];
  cprq_pkg::wr_t     wr;
  logic [IDX_W-1:0]  wr_idx, kill_idx;
  logic              kill_en, clear;
  cprq_pkg::carry_t  fin;
  logic              accept, full;

  function automatic logic [4:0] sat5(input logic [CNT_W-1:0] v);
    logic [31:0] t;
    t = 32'(v);
    return (t > 32'd31) ? 5'd31 : t[4:0];
  endfunction

  assign chain[0] = '0;
  assign bidx[0]  = '0;
  assign fidx[0]  = '0;

  for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
    cprq_cell #(.IDX_W(IDX_W), .CELL_ID(g)) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .levels   (levels_r),
      .cmd      (cmd_r),
      .carry_i  (chain[g]),
      .bidx_i   (bidx[g]),
      .fidx_i   (fidx[g]),
      .carry_o  (chain[g+1]),
      .bidx_o   (bidx[g+1]),
      .fidx_o   (fidx[g+1]),
      .wr       (wr),
      .wr_idx   (wr_idx),
      .kill_en  (kill_en),
      .kill_idx (kill_idx),
      .clear    (clear)
    );
  end

  assign fin    = chain[QUEUE_DEPTH];
  assign accept = start && state_r == S_IDLE;
  assign full   = (32'(total_r) + ((cls_r == cprq_pkg::CLASS_SHUTDOWN) ? 32'd2 : 32'd1))
                  > 32'(QUEUE_DEPTH);

  always_comb begin
    state_nxt  = state_r;
    cnt_nxt    = cnt_r;
    pass2_nxt  = pass2_r;
    term_nxt   = term_r;
    arr_nxt    = arr_r;
    total_nxt  = total_r;
    net_nxt    = net_r;
    win_nxt    = win_r;
    adm_nxt    = adm_r;
    levels_nxt = levels_r;
    mode_nxt   = mode_r;
    cls_nxt    = cls_r;
    tmr_nxt    = tmr_r;
    cmd_nxt    = cmd_r;
    ov_nxt     = 1'b0;
    ost_nxt    = ost_r;
    ocls_nxt   = ocls_r;
    oseq_nxt   = oseq_r;
    otmr_nxt   = otmr_r;
    owin_nxt   = owin_r;
    owrd_nxt   = owrd_r;
    olng_nxt   = olng_r;
    wr         = '0;
    wr_idx     = fidx[QUEUE_DEPTH];
    kill_en    = 1'b0;
    kill_idx   = bidx[QUEUE_DEPTH];
    clear      = 1'b0;

    if (cfg_valid && cfg_index <= cprq_pkg::REG_DEFAULT) levels_nxt[cfg_index] = cfg_data;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          mode_nxt    = in_mode;
          cls_nxt     = in_event_class;
          tmr_nxt     = in_timer_flag;
          cmd_nxt.win = in_window_handle;
          cmd_nxt.wrd = in_word_param;
          cmd_nxt.lng = in_long_param;
          cnt_nxt     = '0;
          pass2_nxt   = 1'b0;
          state_nxt   = S_SCAN;
        end
      end
      S_SCAN: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == LAST) state_nxt = S_EXEC;
      end
      S_EXEC: begin
        state_nxt = S_IDLE;
        ov_nxt    = 1'b1;
        ocls_nxt  = '0;
        oseq_nxt  = '0;
        otmr_nxt  = 1'b0;
        owin_nxt  = '0;
        owrd_nxt  = '0;
        olng_nxt  = '0;
        unique case (mode_r)
          cprq_pkg::MODE_PUT: begin
            if (!pass2_r && term_r && cls_r != cprq_pkg::CLASS_SYNC) begin
              ost_nxt = cprq_pkg::ST_TERM_DROP;
            end else if (!pass2_r && cls_r == cprq_pkg::CLASS_WINDOW && fin.dup) begin
              ost_nxt = cprq_pkg::ST_DUP;
            end else if (!pass2_r && full) begin
              ost_nxt = cprq_pkg::ST_FULL;
            end else begin
              ost_nxt   = cprq_pkg::ST_QUEUED;
              arr_nxt   = arr_r + 32'd1;
              wr.en     = 1'b1;
              wr.cls    = cls_r;
              wr.seq    = arr_nxt;
              wr.tmr    = tmr_r;
              wr.win    = cmd_r.win;
              wr.wrd    = cmd_r.wrd;
              wr.lng    = cmd_r.lng;
              total_nxt = total_r + 1'b1;
              case (cls_r)
                cprq_pkg::CLASS_TIMER:   ;
                cprq_pkg::CLASS_NETWORK: net_nxt = net_r + 1'b1;
                cprq_pkg::CLASS_WINDOW:  win_nxt = win_r + 1'b1;
                default:                 adm_nxt = adm_r + 1'b1;
              endcase
              // shutdown gets a second copy from a fresh pass
              if (cls_r == cprq_pkg::CLASS_SHUTDOWN && !pass2_r) begin
                pass2_nxt = 1'b1;
                cnt_nxt   = '0;
                state_nxt = S_SCAN;
                ov_nxt    = 1'b0;
              end
            end
          end
          cprq_pkg::MODE_GET: begin
            if (fin.found) begin
              ost_nxt  = cprq_pkg::ST_GIVEN;
              ocls_nxt = fin.cls;
              oseq_nxt = fin.seq;
              otmr_nxt = fin.tmr;
              owin_nxt = fin.win;
              owrd_nxt = fin.wrd;
              olng_nxt = fin.lng;
              kill_en  = 1'b1;
              if (total_r != '0) total_nxt = total_r - 1'b1;
              case (fin.cls)
                cprq_pkg::CLASS_TIMER:   ;
                cprq_pkg::CLASS_NETWORK: if (net_r != '0) net_nxt = net_r - 1'b1;
                cprq_pkg::CLASS_WINDOW:  if (win_r != '0) win_nxt = win_r - 1'b1;
                default:                 if (adm_r != '0) adm_nxt = adm_r - 1'b1;
              endcase
            end else begin
              ost_nxt  = cprq_pkg::ST_EMPTY;
              ocls_nxt = cprq_pkg::CLASS_IDLE;
            end
          end
          cprq_pkg::MODE_TERM: begin
            ost_nxt   = cprq_pkg::ST_CLEARED;
            term_nxt  = 1'b1;
            clear     = 1'b1;
            total_nxt = '0;
            net_nxt   = '0;
            win_nxt   = '0;
            adm_nxt   = '0;
          end
          default: begin
            ost_nxt  = cprq_pkg::ST_EMPTY;
            ocls_nxt = cprq_pkg::CLASS_IDLE;
          end
        endcase
      end
      default: state_nxt = S_IDLE;
    endcase

    oocc_nxt = sat5(total_nxt);
    onet_nxt = sat5(net_nxt);
    owc_nxt  = sat5(win_nxt);
    oadm_nxt = sat5(adm_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      cnt_r    <= '0;
      pass2_r  <= 1'b0;
      term_r   <= 1'b0;
      arr_r    <= '0;
      total_r  <= '0;
      net_r    <= '0;
      win_r    <= '0;
      adm_r    <= '0;
      levels_r <= cprq_pkg::LEVELS_RESET;
      ov_r     <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      cnt_r    <= cnt_nxt;
      pass2_r  <= pass2_nxt;
      term_r   <= term_nxt;
      arr_r    <= arr_nxt;
      total_r  <= total_nxt;
      net_r    <= net_nxt;
      win_r    <= win_nxt;
      adm_r    <= adm_nxt;
      levels_r <= levels_nxt;
      ov_r     <= ov_nxt;
    end
    mode_r <= mode_nxt;
    cls_r  <= cls_nxt;
    tmr_r  <= tmr_nxt;
    cmd_r  <= cmd_nxt;
    ost_r  <= ost_nxt;
    ocls_r <= ocls_nxt;
    oseq_r <= oseq_nxt;
    otmr_r <= otmr_nxt;
    owin_r <= owin_nxt;
    owrd_r <= owrd_nxt;
    olng_r <= olng_nxt;
    oocc_r <= oocc_nxt;
    onet_r <= onet_nxt;
    owc_r  <= owc_nxt;
    oadm_r <= oadm_nxt;
  end

  assign busy              = state_r != S_IDLE;
  assign cfg_ready         = 1'b1;
  assign out_valid         = ov_r;
  assign out_status        = ost_r;
  assign out_class         = ocls_r;
  assign out_sequence      = oseq_r;
  assign out_timer_flag    = otmr_r;
  assign out_window        = owin_r;
  assign out_word          = owrd_r;
  assign out_long          = olng_r;
  assign out_occupancy     = oocc_r;
  assign out_network_count = onet_r;
  assign out_window_count  = owc_r;
  assign out_admin_count   = oadm_r;

  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r |=> !ov_r) else $error("result strobe longer than one cycle");

  a_total_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(total_r) <= 32'(QUEUE_DEPTH)) else $error("occupancy above depth");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> busy) else $error("command transfer did not start a pass");

  a_counts_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(net_r) + 32'(win_r) + 32'(adm_r) <= 32'(total_r))
    else $error("class counts exceed occupancy");

endmodule

/* verif/class_priority_request_queue_tb.sv */
// class_priority_request_queue_tb: self-checking bench for the class priority request queue
// predicts every result from its own copy of the queue, levels and counts; depends on cprq_pkg
`timescale 1ns / 1ps

module class_priority_request_queue_tb;

  localparam int DEPTH = cprq_pkg::DEFAULT_DEPTH;
  localparam int SETTLE_CYCLES = 2 * DEPTH + 8;
  localparam int CYCLE_LIMIT = 1000000;

  typedef struct packed {
    logic [2:0]  status;
    logic [2:0]  cls;
    logic [31:0] seq;
    logic        tmr;
    logic [31:0] win;
    logic [31:0] wrd;
    logic [31:0] lng;
    logic [4:0]  occ;
    logic [4:0]  net_cnt;
    logic [4:0]  win_cnt;
    logic [4:0]  adm_cnt;
  } answer_t;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [1:0]  in_mode;
  logic [2:0]  in_event_class;
  logic        in_timer_flag;
  logic [31:0] in_window_handle;
  logic [31:0] in_word_param;
  logic [31:0] in_long_param;
  logic        out_valid;
  logic [2:0]  out_status;
  logic [2:0]  out_class;
  logic [31:0] out_sequence;
  logic        out_timer_flag;
  logic [31:0] out_window;
  logic [31:0] out_word;
  logic [31:0] out_long;
  logic [4:0]  out_occupancy;
  logic [4:0]  out_network_count;
  logic [4:0]  out_window_count;
  logic [4:0]  out_admin_count;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_index;
  logic [7:0]  cfg_data;

  class_priority_request_queue #(.QUEUE_DEPTH(DEPTH)) uut (.*);

  // shadow copy of the queue
  logic [7:0]  lvl [cprq_pkg::LEVEL_COUNT];
  logic        q_valid [DEPTH];
  logic [2:0]  q_cls [DEPTH];
  logic [31:0] q_seq [DEPTH];
  logic        q_tmr [DEPTH];
  logic [31:0] q_win [DEPTH];
  logic [31:0] q_wrd [DEPTH];
  logic [31:0] q_lng [DEPTH];
  logic [31:0] arrivals;
  logic        closing;
  int unsigned n_total, n_net, n_win, n_adm;

  answer_t pending_answers[$];
  int      mismatches;
  int      cycles;
  int      idle_pct;
  logic [31:0] pool [4] = '{32'h0, 32'hFFFF_FFFF, 32'h1, 32'h8000_0000};
  logic [2:0]  reg_order [cprq_pkg::LEVEL_COUNT] =
    '{cprq_pkg::REG_SHUTDOWN, cprq_pkg::REG_NETWORK, cprq_pkg::REG_TIMER,
      cprq_pkg::REG_WINDOW, cprq_pkg::REG_IDLE, cprq_pkg::REG_DEFAULT};

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic logic [7:0] urgency(input logic [2:0] c);
    case (c)
      cprq_pkg::CLASS_SHUTDOWN:   return lvl[cprq_pkg::REG_SHUTDOWN];
      cprq_pkg::CLASS_DISCONNECT,
      cprq_pkg::CLASS_NETWORK:    return lvl[cprq_pkg::REG_NETWORK];
      cprq_pkg::CLASS_TIMER:      return lvl[cprq_pkg::REG_TIMER];
      cprq_pkg::CLASS_WINDOW:     return lvl[cprq_pkg::REG_WINDOW];
      cprq_pkg::CLASS_IDLE:       return lvl[cprq_pkg::REG_IDLE];
      default:                    return lvl[cprq_pkg::REG_DEFAULT];
    endcase
  endfunction

  function automatic void bump_count(input logic [2:0] c, input bit add);
    if (c == cprq_pkg::CLASS_TIMER) return;
    if (c == cprq_pkg::CLASS_NETWORK) begin
      if (add) n_net++; else if (n_net > 0) n_net--;
    end else if (c == cprq_pkg::CLASS_WINDOW) begin
      if (add) n_win++; else if (n_win > 0) n_win--;
    end else begin
      if (add) n_adm++; else if (n_adm > 0) n_adm--;
    end
  endfunction

  function automatic void enqueue(input logic [2:0] c, input logic tf,
                                  input logic [31:0] w, wp, lp);
    for (int i = 0; i < DEPTH; i++) begin
      if (!q_valid[i]) begin
        arrivals = arrivals + 1;
        q_valid[i] = 1'b1;
        q_cls[i] = c;
        q_seq[i] = arrivals;
        q_tmr[i] = tf;
        q_win[i] = w;
        q_wrd[i] = wp;
        q_lng[i] = lp;
        n_total++;
        bump_count(c, 1'b1);
        return;
      end
    end
  endfunction

  function automatic logic [4:0] clip5(input int unsigned v);
    return (v > 31) ? 5'd31 : v[4:0];
  endfunction

  function automatic answer_t queue_response(input logic [1:0] m, input logic [2:0] c,
                                             input logic tf, input logic [31:0] w, wp, lp);
    answer_t a;
    int need;
    bit dup;
    int best;
    logic [7:0] blev;
    logic [31:0] bseq;
    a = '0;
    a.status = cprq_pkg::ST_EMPTY;
    if (m == cprq_pkg::MODE_PUT) begin
      need = (c == cprq_pkg::CLASS_SHUTDOWN) ? 2 : 1;
      dup = 0;
      if (c == cprq_pkg::CLASS_WINDOW)
        for (int i = 0; i < DEPTH; i++)
          if (q_valid[i] && q_cls[i] == cprq_pkg::CLASS_WINDOW && q_tmr[i] && q_win[i] == w &&
              q_wrd[i] == wp && q_lng[i] == lp) dup = 1;
      if (closing && c != cprq_pkg::CLASS_SYNC) a.status = cprq_pkg::ST_TERM_DROP;
      else if (dup) a.status = cprq_pkg::ST_DUP;
      else if (n_total + need > DEPTH) a.status = cprq_pkg::ST_FULL;
      else begin
        enqueue(c, tf, w, wp, lp);
        if (need == 2) enqueue(c, tf, w, wp, lp);
        a.status = cprq_pkg::ST_QUEUED;
      end
    end else if (m == cprq_pkg::MODE_GET) begin
      best = -1;
      blev = '0;
      bseq = '0;
      for (int i = 0; i < DEPTH; i++)
        if (q_valid[i] && (best < 0 || urgency(q_cls[i]) < blev ||
            (urgency(q_cls[i]) == blev && q_seq[i] < bseq))) begin
          best = i;
          blev = urgency(q_cls[i]);
          bseq = q_seq[i];
        end
      if (best < 0) a.cls = cprq_pkg::CLASS_IDLE;
      else begin
        a.status = cprq_pkg::ST_GIVEN;
        a.cls = q_cls[best];
        a.seq = q_seq[best];
        a.tmr = q_tmr[best];
        a.win = q_win[best];
        a.wrd = q_wrd[best];
        a.lng = q_lng[best];
        q_valid[best] = 1'b0;
        if (n_total > 0) n_total--;
        bump_count(q_cls[best], 1'b0);
      end
    end else if (m == cprq_pkg::MODE_TERM) begin
      closing = 1'b1;
      for (int i = 0; i < DEPTH; i++) q_valid[i] = 1'b0;
      n_total = 0;
      n_net = 0;
      n_win = 0;
      n_adm = 0;
      a.status = cprq_pkg::ST_CLEARED;
    end else begin
      a.cls = cprq_pkg::CLASS_IDLE;
    end
    a.occ = clip5(n_total);
    a.net_cnt = clip5(n_net);
    a.win_cnt = clip5(n_win);
    a.adm_cnt = clip5(n_adm);
    return a;
  endfunction

  // one command transfer; start is dropped afterwards unless the next call raises it
  task automatic send_request(input logic [1:0] m, input logic [2:0] c, input logic tf,
                              input logic [31:0] w, wp, lp);
    if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      start = 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
    start = 1'b1;
    in_mode = m;
    in_event_class = c;
    in_timer_flag = tf;
    in_window_handle = w;
    in_word_param = wp;
    in_long_param = lp;
    do @(posedge clk); while (busy);
    pending_answers.push_back(queue_response(m, c, tf, w, wp, lp));
    @(negedge clk);
    start = 1'b0;
  endtask

  task automatic wait_idle();
    while (pending_answers.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_level(input logic [2:0] idx, input logic [7:0] val);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    do @(posedge clk); while (!cfg_ready);
    lvl[idx] = val;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  function automatic logic [31:0] pick_value();
    return ($urandom_range(1) == 0) ? pool[$urandom_range(3)] : $urandom;
  endfunction

  task automatic send_random(input int put_pct);
    int r;
    logic [1:0] m;
    r = $urandom_range(99);
    if (r < 2) m = cprq_pkg::MODE_SPARE;
    else if (r < put_pct) m = cprq_pkg::MODE_PUT;
    else m = cprq_pkg::MODE_GET;
    send_request(m, 3'($urandom_range(7)), 1'($urandom_range(1)),
                 pick_value(), pick_value(), pick_value());
  endtask

  task automatic test_empty_and_classes();
    send_request(cprq_pkg::MODE_GET, cprq_pkg::CLASS_ADMIN, 1'b0, '0, '0, '0);
    send_request(cprq_pkg::MODE_SPARE, cprq_pkg::CLASS_SYNC, 1'b1, '1, '1, '1);
    for (int c = 0; c < 8; c++)
      send_request(cprq_pkg::MODE_PUT, 3'(c), c[0], (c[1] ? '1 : '0), (c[0] ? '1 : '0),
                   32'(c));
    for (int i = 0; i < 10; i++)
      send_request(cprq_pkg::MODE_GET, cprq_pkg::CLASS_ADMIN, 1'b0, '0, '0, '0);
  endtask

  task automatic test_duplicate_timer();
    send_request(cprq_pkg::MODE_PUT, cprq_pkg::CLASS_WINDOW, 1'b1, 32'h1234, 32'h55, 32'h77);
    send_request(cprq_pkg::MODE_PUT, cprq_pkg::CLASS_WINDOW, 1'b0, 32'h1234, 32'h55, 32'h77);
    send_request(cprq_pkg::MODE_PUT, cprq_pkg::CLASS_WINDOW, 1'b1, 32'h1234, 32'h55, 32'h78);
    send_request(cprq_pkg::MODE_PUT, cprq_pkg::CLASS_WINDOW, 1'b1, 32'h1234, 32'h55, 32'h78);
    repeat (3) send_request(cprq_pkg::MODE_GET, cprq_pkg::CLASS_ADMIN, 1'b0, '0, '0, '0);
  endtask

  task automatic test_full_queue();
    for (int i = 0; i < DEPTH - 1; i++)
      send_request(cprq_pkg::MODE_PUT, cprq_pkg::CLASS_NETWORK, 1'b0,
                   $urandom, $urandom, $urandom);
    send_request(cprq_pkg::MODE_PUT, cprq_pkg::CLASS_SHUTDOWN, 1'b0, '1, '1, '1);
    send_request(cprq_pkg::MODE_PUT, cprq_pkg::CLASS_TIMER, 1'b1, '1, '0, '1);
    send_request(cprq_pkg::MODE_PUT, cprq_pkg::CLASS_ADMIN, 1'b0, '0, '1, '0);
    for (int i = 0; i < DEPTH + 1; i++)
      send_request(cprq_pkg::MODE_GET, cprq_pkg::CLASS_ADMIN, 1'b0, '0, '0, '0);
  endtask

  // kind 0: all zero, 1: all 255, else random
  task automatic test_random_phase(input int kind, input int gap_pct, input int count,
                                   input int put_pct);
    wait_idle();
    foreach (reg_order[i])
      write_level(reg_order[i], (kind == 0) ? 8'h00 : (kind == 1) ? 8'hFF : 8'($urandom));
    idle_pct = gap_pct;
    repeat (count) send_random(put_pct);
    idle_pct = 0;
  endtask

  task automatic test_terminate();
    wait_idle();
    repeat (6)
      send_request(cprq_pkg::MODE_PUT, 3'($urandom_range(7)), 1'b0,
                   $urandom, $urandom, $urandom);
    send_request(cprq_pkg::MODE_TERM, cprq_pkg::CLASS_ADMIN, 1'b0, '0, '0, '0);
    send_request(cprq_pkg::MODE_PUT, cprq_pkg::CLASS_ADMIN, 1'b0, '0, '0, '0);
    send_request(cprq_pkg::MODE_PUT, cprq_pkg::CLASS_SYNC, 1'b1, '1, '1, '1);
    repeat (100) send_random(60);
    send_request(cprq_pkg::MODE_TERM, cprq_pkg::CLASS_SYNC, 1'b1, '1, '1, '1);
  endtask

  // result checker
  always @(posedge clk) begin
    answer_t got, want;
    if (rst_n && out_valid) begin
      got = '{out_status, out_class, out_sequence, out_timer_flag, out_window, out_word,
              out_long, out_occupancy, out_network_count, out_window_count, out_admin_count};
      if (pending_answers.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result: %p", got);
      end else begin
        want = pending_answers.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch: expected %p got %p", want, got);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("FAIL class_priority_request_queue");
      $finish;
    end
  end

  initial begin
    mismatches = 0;
    cycles = 0;
    idle_pct = 0;
    rst_n = 1'b0;
    start = 1'b0;
    in_mode = cprq_pkg::MODE_PUT;
    in_event_class = cprq_pkg::CLASS_ADMIN;
    in_timer_flag = 1'b0;
    in_window_handle = '0;
    in_word_param = '0;
    in_long_param = '0;
    cfg_valid = 1'b0;
    cfg_index = cprq_pkg::REG_SHUTDOWN;
    cfg_data = '0;
    for (int i = 0; i < cprq_pkg::LEVEL_COUNT; i++) lvl[i] = cprq_pkg::LEVELS_RESET[i];
    for (int i = 0; i < DEPTH; i++) q_valid[i] = 1'b0;
    arrivals = '0;
    closing = 1'b0;
    n_total = 0;
    n_net = 0;
    n_win = 0;
    n_adm = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    // short quiet spell after reset
    repeat (SETTLE_CYCLES) @(negedge clk);

    test_empty_and_classes();
    test_duplicate_timer();
    test_full_queue();
    test_random_phase(0, 0, 450, 60);
    test_random_phase(1, 49, 450, 50);
    test_random_phase(2, 0, 400, 45);
    test_random_phase(2, 12, 400, 55);
    test_terminate();
    wait_idle();

    if (mismatches == 0 && pending_answers.size() == 0)
      $display("PASS class_priority_request_queue");
    else
      $display("FAIL class_priority_request_queue");
    $finish;
  end

endmodule

/* filelist.f */
src/cprq_pkg.sv
src/cprq_cell.sv
src/class_priority_request_queue.sv
verif/class_priority_request_queue_tb.sv
